FILE: rtl/ati_pkg.sv
// Shared types and constants for the affine transform inverter.
`timescale 1ns / 1ps

package ati_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QW        = 32;
    localparam int NCH       = 6;
    localparam int DIV_STEPS = QW;
    localparam int DW        = 64;
    localparam int NW        = 66 + FRAC_BITS;
    localparam int CW        = DW + QW;

    typedef struct packed {
        logic signed [31:0] fwd_x_from_x;
        logic signed [31:0] fwd_x_from_y;
        logic signed [31:0] fwd_x_shift;
        logic signed [31:0] fwd_y_from_x;
        logic signed [31:0] fwd_y_from_y;
        logic signed [31:0] fwd_y_shift;
        logic signed [31:0] extra_offset;
    } t_in;

    typedef struct packed {
        logic signed [31:0] inv_x_from_x;
        logic signed [31:0] inv_x_from_y;
        logic signed [31:0] inv_x_shift;
        logic signed [31:0] inv_y_from_x;
        logic signed [31:0] inv_y_from_y;
        logic signed [31:0] inv_y_shift;
        logic               singular;
        logic               saturated;
    } t_out;

    typedef struct packed {
        logic          neg;
        logic          ovf;
        logic [DW-1:0] rem;
        logic [QW-1:0] lq;
    } t_ch;

    typedef struct packed {
        logic                sing;
        logic [DW-1:0]       d;
        t_ch [NCH-1:0]       ch;
    } t_dst;

    typedef struct packed {
        logic          neg;
        logic          ovf;
        logic [QW:0]   qv;
    } t_rnd;

endpackage

FILE: rtl/affine_transform_inverter.sv
// Top level: pipelined inverse of a 2-D affine transform in signed fixed point.
//
// channel  direction  payload  handshake
// in       input      t_in     i_in_valid / o_in_stall
// out      output     t_out    o_out_valid / i_out_stall
//
// An item can enter in every cycle while o_in_stall is low; values are signed Q16.16, and
// the six restoring dividers resolve one quotient bit per stage.
// Reset is synchronous and active low; it clears the valid bits only.
// The pipeline advances as one while the skid register is empty; a stalled output
// fills the skid register and the input is stalled on the following cycle.
`timescale 1ns / 1ps

module affine_transform_inverter import ati_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    logic en;

    logic               r_v0;
    logic signed [31:0] r0_a, r0_b, r0_d, r0_e;
    logic signed [32:0] r0_cp, r0_fp;

    logic               r_v1;
    logic signed [31:0] r1_a, r1_b, r1_d, r1_e;
    logic signed [63:0] r1_ae, r1_bd;
    logic signed [64:0] r1_bf, r1_ce, r1_cd, r1_af;

    logic               r_v2;
    logic signed [64:0] r2_det;
    logic signed [65:0] r2_nx, r2_ny;
    logic signed [32:0] r2_cn [4];

    logic               r_v3;
    logic               r3_sing;
    logic [DW-1:0]      r3_d;
    logic [NW-1:0]      r3_mag [NCH];
    logic               r3_neg [NCH];

    logic [DIV_STEPS:0] r_dv;
    t_dst               r_ds [DIV_STEPS+1];

    logic               r_v5;
    logic               r5_sing;
    t_rnd               r5_r [NCH];

    logic               r_v6;
    t_out               r6_res, n6_res;

    logic               r_ov, r_full;
    t_out               r_od, r_sk;

    logic [DW-1:0]      n3_d;
    logic [NW-1:0]      n3_mag [NCH];
    logic               n3_neg [NCH];
    logic               n3_nneg [NCH];
    logic [32:0]        n3_cabs [4];
    logic [65:0]        n3_tabs [2];
    t_dst               n4_ds;
    t_rnd               n5_r [NCH];
    logic [QW-1:0]      n6_val [NCH];
    logic               n6_sat;

    assign en = !r_full;
    assign o_in_stall = r_full;

    function automatic t_ch f_step(t_ch c, logic [DW-1:0] d);
        logic [DW:0]   t;
        logic [DW+1:0] diff;
        logic          ge;
        t_ch           r;
        t    = {c.rem, c.lq[QW-1]};
        diff = {1'b0, t} - {2'b00, d};
        ge   = !diff[DW+1];
        r     = c;
        r.rem = ge ? diff[DW-1:0] : t[DW-1:0];
        r.lq  = {c.lq[QW-2:0], ge};
        return r;
    endfunction

    // Stage 0: input register and offset sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_in_valid;
        end
        if (en) begin
            r0_a  <= i_in.fwd_x_from_x;
            r0_b  <= i_in.fwd_x_from_y;
            r0_d  <= i_in.fwd_y_from_x;
            r0_e  <= i_in.fwd_y_from_y;
            r0_cp <= 33'(i_in.fwd_x_shift) + 33'(i_in.extra_offset);
            r0_fp <= 33'(i_in.fwd_y_shift) + 33'(i_in.extra_offset);
        end
    end

    // Stage 1: products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= r_v0;
        end
        if (en) begin
            r1_a  <= r0_a;
            r1_b  <= r0_b;
            r1_d  <= r0_d;
            r1_e  <= r0_e;
            r1_ae <= r0_a * r0_e;
            r1_bd <= r0_b * r0_d;
            r1_bf <= r0_b * r0_fp;
            r1_ce <= r0_cp * r0_e;
            r1_cd <= r0_cp * r0_d;
            r1_af <= r0_a * r0_fp;
        end
    end

    // Stage 2: determinant and numerators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
        if (en) begin
            r2_det   <= 65'(r1_ae) - 65'(r1_bd);
            r2_nx    <= 66'(r1_bf) - 66'(r1_ce);
            r2_ny    <= 66'(r1_cd) - 66'(r1_af);
            r2_cn[0] <= 33'(r1_e);
            r2_cn[1] <= -33'(r1_b);
            r2_cn[2] <= -33'(r1_d);
            r2_cn[3] <= 33'(r1_a);
        end
    end

    // Stage 3: magnitudes and signs.
    always_comb begin
        n3_d = r2_det[64] ? DW'(-r2_det) : DW'(r2_det);
        for (int i = 0; i < 4; i++) begin
            n3_cabs[i] = r2_cn[i][32] ? -r2_cn[i] : r2_cn[i];
        end
        n3_tabs[0] = r2_nx[65] ? -r2_nx : r2_nx;
        n3_tabs[1] = r2_ny[65] ? -r2_ny : r2_ny;
        n3_mag[0]  = NW'(n3_cabs[0]) << (2 * FRAC_BITS);
        n3_mag[1]  = NW'(n3_cabs[1]) << (2 * FRAC_BITS);
        n3_mag[2]  = NW'(n3_tabs[0]) << FRAC_BITS;
        n3_mag[3]  = NW'(n3_cabs[2]) << (2 * FRAC_BITS);
        n3_mag[4]  = NW'(n3_cabs[3]) << (2 * FRAC_BITS);
        n3_mag[5]  = NW'(n3_tabs[1]) << FRAC_BITS;
        n3_nneg[0] = r2_cn[0][32];
        n3_nneg[1] = r2_cn[1][32];
        n3_nneg[2] = r2_nx[65];
        n3_nneg[3] = r2_cn[2][32];
        n3_nneg[4] = r2_cn[3][32];
        n3_nneg[5] = r2_ny[65];
        for (int i = 0; i < NCH; i++) begin
            n3_neg[i] = n3_nneg[i] ^ r2_det[64];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
        if (en) begin
            r3_sing <= (r2_det == '0);
            r3_d    <= n3_d;
            for (int i = 0; i < NCH; i++) begin
                r3_mag[i] <= n3_mag[i];
                r3_neg[i] <= n3_neg[i];
            end
        end
    end

    // Stage 4: overflow test and divider set-up.
    always_comb begin
        n4_ds.sing = r3_sing;
        n4_ds.d    = r3_d;
        for (int i = 0; i < NCH; i++) begin
            n4_ds.ch[i].neg = r3_neg[i];
            n4_ds.ch[i].ovf = CW'(r3_mag[i]) >= {r3_d, QW'(0)};
            n4_ds.ch[i].rem = DW'(r3_mag[i] >> QW);
            n4_ds.ch[i].lq  = r3_mag[i][QW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_v3;
        end
        if (en) begin
            r_ds[0] <= n4_ds;
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        t_dst n_ds;
        always_comb begin
            n_ds = r_ds[k];
            for (int i = 0; i < NCH; i++) begin
                n_ds.ch[i] = f_step(r_ds[k].ch[i], r_ds[k].d);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
            if (en) begin
                r_ds[k+1] <= n_ds;
            end
        end
    end

    // Stage 5: round to nearest, ties away from zero.
    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            n5_r[i].neg = r_ds[DIV_STEPS].ch[i].neg;
            n5_r[i].ovf = r_ds[DIV_STEPS].ch[i].ovf;
            n5_r[i].qv  = {1'b0, r_ds[DIV_STEPS].ch[i].lq}
                        + (QW+1)'({r_ds[DIV_STEPS].ch[i].rem, 1'b0}
                                  >= {1'b0, r_ds[DIV_STEPS].d});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v5 <= r_dv[DIV_STEPS];
        end
        if (en) begin
            r5_sing <= r_ds[DIV_STEPS].sing;
            for (int i = 0; i < NCH; i++) begin
                r5_r[i] <= n5_r[i];
            end
        end
    end

    // Stage 6: saturation and sign.
    always_comb begin
        logic [QW:0]   lim;
        logic [QW-1:0] mv;
        n6_sat = 1'b0;
        for (int i = 0; i < NCH; i++) begin
            lim = r5_r[i].neg ? {2'b01, (QW-1)'(0)} : {2'b00, {(QW-1){1'b1}}};
            if (r5_r[i].ovf || (r5_r[i].qv > lim)) begin
                mv     = lim[QW-1:0];
                n6_sat = 1'b1;
            end else begin
                mv = r5_r[i].qv[QW-1:0];
            end
            n6_val[i] = r5_r[i].neg ? -mv : mv;
        end
        if (r5_sing) begin
            n6_res = '0;
            n6_res.singular = 1'b1;
        end else begin
            n6_res.inv_x_from_x = n6_val[0];
            n6_res.inv_x_from_y = n6_val[1];
            n6_res.inv_x_shift  = n6_val[2];
            n6_res.inv_y_from_x = n6_val[3];
            n6_res.inv_y_from_y = n6_val[4];
            n6_res.inv_y_shift  = n6_val[5];
            n6_res.singular     = 1'b0;
            n6_res.saturated    = n6_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v6 <= r_v5;
        end
        if (en) begin
            r6_res <= n6_res;
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_full <= 1'b0;
        end else if (!r_ov || !i_out_stall) begin
            if (r_full) begin
                r_ov   <= 1'b1;
                r_full <= 1'b0;
            end else begin
                r_ov <= en && r_v6;
            end
        end else if (en && r_v6) begin
            r_full <= 1'b1;
        end
        if (!r_ov || !i_out_stall) begin
            r_od <= r_full ? r_sk : r6_res;
        end else if (en && r_v6) begin
            r_sk <= r6_res;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_od;

    a_full_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> r_ov)
        else $error("skid register holds a transfer while the output is empty");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_od.singular) |-> (!r_od.saturated && r_od.inv_x_from_x == '0
            && r_od.inv_x_from_y == '0 && r_od.inv_x_shift == '0
            && r_od.inv_y_from_x == '0 && r_od.inv_y_from_y == '0
            && r_od.inv_y_shift == '0))
        else $error("singular result carries non-zero fields or saturation");

    a_skid_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_out_stall && r_v6 && !r_full) |=> r_full)
        else $error("result arriving at a stalled output was not kept");

endmodule

FILE: test/ati_checker.sv
// Checker for the affine transform inverter: predicts each inverse and compares the results.
`timescale 1ns / 1ps

module ati_checker import ati_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in         i_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out        i_out,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_singular_seen,
    output int          o_saturated_seen
);

    t_out inverse_queue[$];

    // Rounded division of two exact values; ties go away from zero, overflow clips.
    function automatic logic [31:0] round_quotient(input logic signed [191:0] num,
                                                   input logic signed [191:0] den,
                                                   inout logic sat);
        logic [191:0] mag;
        logic [191:0] dmag;
        logic [191:0] quo;
        logic [191:0] rem;
        logic [191:0] lim;
        logic         neg;
        mag  = num[191] ? -num : num;
        dmag = den[191] ? -den : den;
        neg  = num[191] != den[191];
        lim  = neg ? 192'h8000_0000 : 192'h7FFF_FFFF;
        quo  = mag / dmag;
        rem  = mag % dmag;
        if (quo > 192'hFFFF_FFFF) begin
            quo = lim;
            sat = 1'b1;
        end else begin
            if (rem >= dmag - rem)
                quo = quo + 1;
            if (quo > lim) begin
                quo = lim;
                sat = 1'b1;
            end
        end
        if (neg)
            quo = -quo;
        return quo[31:0];
    endfunction

    function automatic t_out invert_transform(input t_in x);
        logic signed [191:0] a, b, c, d, e, f, off, cp, fp, det;
        logic                sat;
        t_out                r;
        a   = x.fwd_x_from_x;
        b   = x.fwd_x_from_y;
        c   = x.fwd_x_shift;
        d   = x.fwd_y_from_x;
        e   = x.fwd_y_from_y;
        f   = x.fwd_y_shift;
        off = x.extra_offset;
        cp  = c + off;
        fp  = f + off;
        det = a * e - b * d;
        sat = 1'b0;
        r   = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        r.inv_x_from_x = round_quotient(e <<< (2 * FRAC_BITS), det, sat);
        r.inv_x_from_y = round_quotient((-b) <<< (2 * FRAC_BITS), det, sat);
        r.inv_x_shift  = round_quotient((b * fp - cp * e) <<< FRAC_BITS, det, sat);
        r.inv_y_from_x = round_quotient((-d) <<< (2 * FRAC_BITS), det, sat);
        r.inv_y_from_y = round_quotient(a <<< (2 * FRAC_BITS), det, sat);
        r.inv_y_shift  = round_quotient((cp * d - a * fp) <<< FRAC_BITS, det, sat);
        r.saturated    = sat;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            inverse_queue.delete();
            o_fail_count     <= 0;
            o_checked        <= 0;
            o_singular_seen  <= 0;
            o_saturated_seen <= 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                inverse_queue.push_back(invert_transform(i_in));
            if (i_out_valid && !i_out_stall) begin
                o_checked <= o_checked + 1;
                if (i_out.singular)
                    o_singular_seen <= o_singular_seen + 1;
                if (i_out.saturated)
                    o_saturated_seen <= o_saturated_seen + 1;
                if (inverse_queue.size() == 0) begin
                    $display("%0t: unexpected transfer, actual %h", $time, i_out);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = inverse_queue.pop_front();
                    if (want !== i_out) begin
                        $display("%0t: mismatch, expected %h actual %h", $time, want, i_out);
                        $display("    fields exp %h %h %h %h %h %h s%b c%b", want.inv_x_from_x,
                                 want.inv_x_from_y, want.inv_x_shift, want.inv_y_from_x,
                                 want.inv_y_from_y, want.inv_y_shift, want.singular,
                                 want.saturated);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= inverse_queue.size();
    end

endmodule

FILE: test/tb_affine_transform_inverter.sv
// Testbench top for the affine transform inverter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_affine_transform_inverter;
    import ati_pkg::*;

    localparam int ONE        = 1 << FRAC_BITS;
    localparam int IDLE_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out;

    int  fail_count, pending, checked, singular_seen, saturated_seen;
    bit  hold_output = 1'b0;
    bit  timed_out = 1'b0;
    int  idle_cycles = 0;
    int  sent = 0;

    affine_transform_inverter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    ati_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_in             (i_in),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_out            (o_out),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_singular_seen  (singular_seen),
        .o_saturated_seen (saturated_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: random stalls, with a long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_output)
            i_out_stall <= 1'b1;
        else if ($urandom_range(0, 3) == 0)
            i_out_stall <= ($urandom_range(0, 9) < 7);
        else if ($urandom_range(0, 49) == 0)
            i_out_stall <= 1'b1;
        else
            i_out_stall <= 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("%0t: timeout, %0d transfers still expected", $time, pending);
            $display("** affine_transform_inverter: FAILED **");
            $finish;
        end
    end

    task automatic send_transform(input t_in x, input bit allow_gap);
        logic stalled;
        int   gap;
        gap = allow_gap ? gap_length() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            i_in       <= '0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= x;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value(input int mode);
        logic signed [31:0] v;
        case (mode)
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
            2: v = $signed($urandom_range(0, 64)) - 32;
            default: begin
                case ($urandom_range(0, 4))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7FFF_FFFF;
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic t_in make_transform(input int mode, input bit degenerate);
        t_in x;
        int  k;
        x.fwd_x_from_x = pick_value(mode);
        x.fwd_x_from_y = pick_value(mode);
        x.fwd_x_shift  = pick_value($urandom_range(0, 3));
        x.fwd_y_shift  = pick_value($urandom_range(0, 3));
        x.extra_offset = ($urandom_range(0, 2) == 0) ? 0 : pick_value($urandom_range(0, 3));
        if (degenerate) begin
            k = $signed($urandom_range(0, 6)) - 3;
            x.fwd_y_from_x = x.fwd_x_from_x * k;
            x.fwd_y_from_y = x.fwd_x_from_y * k;
        end else begin
            x.fwd_y_from_x = pick_value(mode);
            x.fwd_y_from_y = pick_value(mode);
        end
        return x;
    endfunction

    function automatic t_in directed(input int a, input int b, input int c, input int d,
                                     input int e, input int f, input int off);
        t_in x;
        x = '{a, b, c, d, e, f, off};
        return x;
    endfunction

    initial begin
        t_in dir_list[$];
        int  mode;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_list.push_back(directed(ONE, 0, 0, 0, ONE, 0, 0));
        dir_list.push_back(directed(ONE, 0, 5 * ONE, 0, ONE, -3 * ONE, 0));
        dir_list.push_back(directed(ONE, 0, 5 * ONE, 0, ONE, -3 * ONE, 2 * ONE));
        dir_list.push_back(directed(2 * ONE, ONE, 7, ONE, 3 * ONE, -9, -ONE));
        dir_list.push_back(directed(0, ONE, 0, -ONE, 0, ONE, 0));
        dir_list.push_back(directed(0, 0, 0, 0, 0, 0, 0));
        dir_list.push_back(directed(ONE, 2 * ONE, 3, 2 * ONE, 4 * ONE, 5, 0));
        dir_list.push_back(directed(1, 0, 0, 0, 1, 0, 0));
        dir_list.push_back(directed(3 * ONE, 0, ONE, 0, 3 * ONE, ONE, 0));
        dir_list.push_back(directed(2, 0, 1, 0, 2, 3, 0));
        dir_list.push_back(directed(32'h8000_0000, 0, 32'h8000_0000, 0, 32'h8000_0000,
                                    32'h8000_0000, 32'h8000_0000));
        dir_list.push_back(directed(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF));
        dir_list.push_back(directed(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                    32'h7FFF_FFFF));
        dir_list.push_back(directed(32'h8000_0000, 32'h8000_0000, 0, 32'h8000_0000,
                                    32'h8000_0000, 0, 0));
        dir_list.push_back(directed(-1, -1, -1, -1, 1, -1, -1));
        dir_list.push_back(directed(ONE, ONE, 0, ONE, ONE + 1, 0, 32'h7FFF_FFFF));
        dir_list.push_back(directed(-ONE, 0, 0, 0, ONE, 0, -ONE));
        dir_list.push_back(directed(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333,
                                    32'hCCCC_CCCC, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h1234_5678));
        foreach (dir_list[i])
            send_transform(dir_list[i], 1'b0);
        drain();

        for (int n = 0; n < 1900; n++) begin
            if (n == 600) begin
                fork
                    begin
                        hold_output = 1'b1;
                        repeat (400) @(posedge i_clk);
                        hold_output = 1'b0;
                    end
                join_none
            end
            if (n == 1200)
                drain();
            mode = $urandom_range(0, 9);
            mode = (mode < 5) ? 1 : (mode < 7) ? 0 : (mode < 9) ? 2 : 3;
            send_transform(make_transform(mode, $urandom_range(0, 11) == 0),
                           (n < 600 || n > 700));
        end
        i_in_valid <= 1'b0;

        for (int w = 0; w < IDLE_LIMIT && pending != 0; w++)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Run covered %0d transforms sent and %0d inverses checked,", sent, checked);
        $display("of which %0d were singular and %0d saturated.", singular_seen, saturated_seen);
        if (fail_count == 0 && pending == 0)
            $display("** affine_transform_inverter: PASSED **");
        else
            $display("** affine_transform_inverter: FAILED **");
        $finish;
    end

endmodule
